FILE: rtl/rms_pkg.sv
// rms_pkg: shared types and constants of the running median store
// holds op and status codes, cell command struct, fsm states; no dependencies
package rms_pkg;

   localparam int DATA_W       = 32;
   localparam int COUNT_W      = 11;
   localparam int STATUS_W     = 2;
   localparam int CAPACITY_DEF = 1024;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_PUSH
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] key;
   } cell_cmd_type;

   typedef enum logic {
      FSM_IDLE,
      FSM_MOVE
   } fsm_type;

endpackage

FILE: rtl/running_median_store.sv
// running_median_store: lower half kept descending, upper half ascending, in two cell chains
// registered result strobe comes in the cycle after the accepting edge; busy blocks new items
// busy state FSM_MOVE moves at most one head across, keeping the lower half the larger one
// reset: synchronous, clears the count, fsm and strobe; cell contents are left as they are
// rsp_valid is a one-cycle strobe and the receiver cannot stall; depends on rms_pkg, rms_chain
module running_median_store #(
   parameter int CAPACITY = rms_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [rms_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic signed [rms_pkg::DATA_W-1:0]   rsp_median,
   output logic [rms_pkg::STATUS_W-1:0]        rsp_status,
   output logic [rms_pkg::COUNT_W-1:0]         rsp_count
);
   import rms_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   fsm_type                  state_ff, state_in;
   logic [CNT_W-1:0]         held_count_ff, held_count_in;
   logic                     move_l2u_ff, move_l2u_in;
   logic                     move_u2l_ff, move_u2l_in;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_median_ff, rsp_median_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                     accept;
   logic                     is_add;
   logic                     full;
   logic                     empty;
   logic                     do_insert;
   logic                     to_lower;
   logic [CNT_W:0]           count_plus;
   logic [CNT_W-1:0]         size_lower;
   logic [CNT_W-1:0]         size_upper;
   logic signed [DATA_W-1:0] lower_head;
   logic signed [DATA_W-1:0] upper_head;
   cell_cmd_type             cmd_lower;
   cell_cmd_type             cmd_upper;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign busy       = state_ff == FSM_MOVE;
   assign accept     = start && !busy;
   assign is_add     = req_op == OP_ADD;
   assign full       = held_count_ff == CNT_W'(CAPACITY);
   assign empty      = held_count_ff == '0;
   assign do_insert  = accept && is_add && !full;
   assign to_lower   = empty || (req_value <= lower_head);
   assign count_plus = {1'b0, held_count_ff} + 1'b1;
   assign size_lower = count_plus[CNT_W:1];
   assign size_upper = held_count_ff >> 1;

   rms_chain #(
      .CAPACITY (CAPACITY),
      .DESCEND  (1'b1)
   ) u_lower (
      .clock (clock),
      .cmd   (cmd_lower),
      .size  (size_lower),
      .head  (lower_head)
   );

   rms_chain #(
      .CAPACITY (CAPACITY),
      .DESCEND  (1'b0)
   ) u_upper (
      .clock (clock),
      .cmd   (cmd_upper),
      .size  (size_upper),
      .head  (upper_head)
   );

   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      move_l2u_in   = move_l2u_ff;
      move_u2l_in   = move_u2l_ff;
      cmd_lower     = '{op: CELL_HOLD, key: req_value};
      cmd_upper     = '{op: CELL_HOLD, key: req_value};
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in    = FSM_MOVE;
               move_l2u_in = do_insert && to_lower && held_count_ff[0];
               move_u2l_in = do_insert && !to_lower && !held_count_ff[0];
               if (do_insert) begin
                  held_count_in = count_plus[CNT_W-1:0];
                  if (to_lower) begin
                     cmd_lower.op = CELL_INSERT;
                  end else begin
                     cmd_upper.op = CELL_INSERT;
                  end
               end
            end
         end
         FSM_MOVE: begin
            state_in    = FSM_IDLE;
            move_l2u_in = 1'b0;
            move_u2l_in = 1'b0;
            if (move_l2u_ff) begin
               cmd_lower = '{op: CELL_POP,  key: upper_head};
               cmd_upper = '{op: CELL_PUSH, key: lower_head};
            end else if (move_u2l_ff) begin
               cmd_lower = '{op: CELL_PUSH, key: upper_head};
               cmd_upper = '{op: CELL_POP,  key: lower_head};
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_median_in = '0;
      rsp_status_in = ST_OK;
      rsp_count_in  = held_count_ff;
      if (is_add) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_count_in = count_plus[CNT_W-1:0];
         end
      end else if (empty) begin
         rsp_status_in = ST_EMPTY;
      end else begin
         rsp_median_in = lower_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         held_count_ff <= '0;
         move_l2u_ff   <= 1'b0;
         move_u2l_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         move_l2u_ff   <= move_l2u_in;
         move_u2l_ff   <= move_u2l_in;
         rsp_valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_median_ff <= rsp_median_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, rsp_count_ff};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = count_wide[COUNT_W-1:0];

`ifndef SYNTHESIS
   a_beat_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept))
      else $error("result beat without an accepted item");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && rsp_valid)
      else $error("accepted item not followed by busy cycle and result");

   a_single_move: assert property (@(posedge clock) disable iff (reset)
      !(move_l2u_ff && move_u2l_ff))
      else $error("both balance moves requested");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CNT_W'(CAPACITY))
      else $error("held count beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> held_count_ff == CNT_W'(CAPACITY))
      else $error("full status while store has room");
`endif

endmodule

FILE: rtl/rms_cell.sv
// rms_cell: one slot of a sorted chain, holds a single value
// depends on rms_pkg for the cell command struct
module rms_cell #(
   parameter int INDEX   = 0,
   parameter bit DESCEND = 1'b0,
   parameter int CNT_W   = 11
) (
   input  logic                               clock,
   input  rms_pkg::cell_cmd_type              cmd,
   input  logic [CNT_W-1:0]                   size,
   input  logic signed [rms_pkg::DATA_W-1:0]  prev_value,
   input  logic                               prev_keep,
   input  logic signed [rms_pkg::DATA_W-1:0]  next_value,
   output logic signed [rms_pkg::DATA_W-1:0]  value,
   output logic                               keep
);
   import rms_pkg::*;

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     occupied;
   logic                     ordered;

   assign occupied = CNT_W'(INDEX) < size;
   assign ordered  = DESCEND ? (value_ff >= cmd.key) : (value_ff <= cmd.key);
   assign keep     = occupied && ordered;
   assign value    = value_ff;

   always_comb begin
      case (cmd.op)
         CELL_INSERT: begin
            if (keep) begin
               value_in = value_ff;
            end else if (prev_keep) begin
               value_in = cmd.key;
            end else begin
               value_in = prev_value;
            end
         end
         CELL_POP:  value_in = next_value;
         CELL_PUSH: value_in = prev_value;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: rtl/rms_chain.sv
// rms_chain: row of rms_cell slots kept sorted, head at index zero
// depends on rms_pkg and rms_cell
module rms_chain #(
   parameter int CAPACITY = rms_pkg::CAPACITY_DEF,
   parameter bit DESCEND  = 1'b0
) (
   input  logic                                         clock,
   input  rms_pkg::cell_cmd_type                        cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]                size,
   output logic signed [rms_pkg::DATA_W-1:0]            head
);
   import rms_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LENGTH = (CAPACITY + 1) / 2 + 1;

   logic signed [DATA_W-1:0] values [LENGTH];
   logic                     keeps  [LENGTH];

   assign head = values[0];

   for (genvar i = 0; i < LENGTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_value;
      logic                     prev_keep;
      logic signed [DATA_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = cmd.key;
         assign prev_keep  = 1'b0;
      end else begin : g_inner
         assign prev_value = values[i-1];
         assign prev_keep  = keeps[i-1];
      end

      if (i == LENGTH - 1) begin : g_last
         assign next_value = values[i];
      end else begin : g_body
         assign next_value = values[i+1];
      end

      rms_cell #(
         .INDEX   (i),
         .DESCEND (DESCEND),
         .CNT_W   (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .size       (size),
         .prev_value (prev_value),
         .prev_keep  (prev_keep),
         .next_value (next_value),
         .value      (values[i]),
         .keep       (keeps[i])
      );
   end

endmodule
